>>> hdl/sha_pkg.sv
// shared types and constants of the sha-256 stream hasher
// round constants, initial hash values, controller to datapath command and status
package sha_pkg;

    // byte sizes and positions in a 64-byte block
    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [1:0] WORD_LAST = 2'd3;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [63:0] BYTE_BITS = 64'd8;

    // initial hash values, h0 first
    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // source of the byte shifted into the block
    typedef enum logic [1:0] {
        BYTE_INPUT = 2'd0,
        BYTE_PAD80 = 2'd1,
        BYTE_ZERO  = 2'd2,
        BYTE_LEN   = 2'd3
    } t_byte_sel;

    // controller to datapath commands
    typedef struct packed {
        logic      byte_wr;
        t_byte_sel byte_sel;
        logic      len_add;
        logic      load_work;
        logic      round_en;
        logic      fold;
        logic      restart;
        logic [1:0] word_sel;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [5:0] fill;
        logic       round_last;
    } t_dp_status;

    // round constant table
    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

>>> hdl/sha_dp.sv
// datapath of the sha-256 stream hasher: block window, round unit, chain, length
// depends on sha_pkg for commands, status, round constants and initial values
module sha_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha_pkg::t_dp_cmd      i_cmd,
    input  logic [7:0]            i_byte,
    output sha_pkg::t_dp_status   o_status,
    output logic [63:0]           o_digest
);
    import sha_pkg::*;

    logic [31:0]  r_chain [8];
    logic [31:0]  r_v [8];
    logic [511:0] r_win;
    logic [5:0]   r_fill;
    logic [5:0]   r_round;
    logic [63:0]  r_len;

    logic [7:0]   byte_in;
    logic [31:0]  w0;
    logic [31:0]  w1;
    logic [31:0]  w9;
    logic [31:0]  w14;
    logic [31:0]  s0;
    logic [31:0]  s1;
    logic [31:0]  w_new;
    logic [31:0]  big_s0;
    logic [31:0]  big_s1;
    logic [31:0]  ch;
    logic [31:0]  maj;
    logic [31:0]  t1;
    logic [31:0]  t2;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // byte source: input, pad marker, zero fill or big-endian bit length
    always_comb begin
        case (i_cmd.byte_sel)
            BYTE_INPUT: byte_in = i_byte;
            BYTE_PAD80: byte_in = PAD_BYTE;
            BYTE_ZERO:  byte_in = 8'h00;
            BYTE_LEN:   byte_in = r_len[{~r_fill[2:0], 3'b000} +: 8];
            default:    byte_in = 8'h00;
        endcase
    end

    // message schedule taps, oldest word in the top bits
    assign w0  = r_win[511:480];
    assign w1  = r_win[479:448];
    assign w9  = r_win[223:192];
    assign w14 = r_win[63:32];
    assign s0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    assign s1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    assign w_new = w0 + s0 + w9 + s1;

    // one compression round
    assign big_s1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
    assign big_s0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
    assign ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1  = r_v[7] + big_s1 + ch + round_k(r_round) + w0;
    assign t2  = big_s0 + maj;

    // chain value, fill count and bit length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= HASH_IV;
            r_fill  <= '0;
            r_len   <= '0;
        end else begin
            if (i_cmd.byte_wr) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.len_add) begin
                r_len <= r_len + BYTE_BITS;
            end
            if (i_cmd.fold) begin
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= r_chain[i] + r_v[i];
                end
            end
            if (i_cmd.restart) begin
                r_chain <= HASH_IV;
                r_fill  <= '0;
                r_len   <= '0;
            end
        end
    end

    // block window and working variables
    always_ff @(posedge i_clk) begin
        if (i_cmd.byte_wr) begin
            r_win <= {r_win[503:0], byte_in};
        end
        if (i_cmd.load_work) begin
            r_v     <= r_chain;
            r_round <= '0;
        end
        if (i_cmd.round_en) begin
            r_win   <= {r_win[479:0], w_new};
            r_round <= r_round + 6'd1;
            r_v[7]  <= r_v[6];
            r_v[6]  <= r_v[5];
            r_v[5]  <= r_v[4];
            r_v[4]  <= r_v[3] + t1;
            r_v[3]  <= r_v[2];
            r_v[2]  <= r_v[1];
            r_v[1]  <= r_v[0];
            r_v[0]  <= t1 + t2;
        end
    end

    // digest word, h0 and h1 in word 0
    always_comb begin
        case (i_cmd.word_sel)
            2'd0:    o_digest = {r_chain[0], r_chain[1]};
            2'd1:    o_digest = {r_chain[2], r_chain[3]};
            2'd2:    o_digest = {r_chain[4], r_chain[5]};
            default: o_digest = {r_chain[6], r_chain[7]};
        endcase
    end

    assign o_status.fill       = r_fill;
    assign o_status.round_last = (r_round == ROUND_LAST);

endmodule

>>> hdl/sha_ctrl.sv
// controller of the sha-256 stream hasher: absorb, pad, rounds, fold, emit
// depends on sha_pkg for the command and status structs
module sha_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_in_present,
    input  logic                  i_in_last,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_out_word,
    output logic                  o_out_last,
    output sha_pkg::t_dp_cmd      o_cmd,
    input  sha_pkg::t_dp_status   i_status
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_FOLD,
        S_EMIT
    } t_state;

    t_state     r_state, n_state;
    logic       r_pad, n_pad;
    logic       r_first, n_first;
    logic       r_len_ok, n_len_ok;
    logic       r_final, n_final;
    logic [1:0] r_word, n_word;
    logic       len_zone;

    assign len_zone = (i_status.fill >= LEN_START);

    // next state and datapath commands
    always_comb begin
        n_state  = r_state;
        n_pad    = r_pad;
        n_first  = r_first;
        n_len_ok = r_len_ok;
        n_final  = r_final;
        n_word   = r_word;
        o_cmd    = '0;
        o_cmd.word_sel = r_word;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_present) begin
                        o_cmd.byte_wr  = 1'b1;
                        o_cmd.byte_sel = BYTE_INPUT;
                        o_cmd.len_add  = 1'b1;
                    end
                    // a full block goes to the rounds, padding may follow
                    if (i_in_present && i_status.fill == FILL_LAST) begin
                        o_cmd.load_work = 1'b1;
                        n_state = S_ROUND;
                        n_pad   = i_in_last;
                        n_first = 1'b1;
                    end else if (i_in_last) begin
                        n_state = S_PAD;
                        n_pad   = 1'b1;
                        n_first = 1'b1;
                    end
                end
            end
            S_PAD: begin
                o_cmd.byte_wr = 1'b1;
                if (r_first) begin
                    o_cmd.byte_sel = BYTE_PAD80;
                    n_first  = 1'b0;
                    n_len_ok = !len_zone;
                end else if (len_zone && r_len_ok) begin
                    o_cmd.byte_sel = BYTE_LEN;
                end else begin
                    o_cmd.byte_sel = BYTE_ZERO;
                end
                // block complete: the one holding the length is the last
                if (i_status.fill == FILL_LAST) begin
                    o_cmd.load_work = 1'b1;
                    n_state  = S_ROUND;
                    n_final  = !r_first && r_len_ok;
                    n_len_ok = 1'b1;
                end
            end
            S_ROUND: begin
                o_cmd.round_en = 1'b1;
                if (i_status.round_last) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                if (r_final) begin
                    n_state = S_EMIT;
                    n_word  = '0;
                end else if (r_pad) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    if (r_word == WORD_LAST) begin
                        o_cmd.restart = 1'b1;
                        n_state = S_IDLE;
                        n_pad   = 1'b0;
                        n_final = 1'b0;
                    end else begin
                        n_word = r_word + 2'd1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pad    <= 1'b0;
            r_first  <= 1'b0;
            r_len_ok <= 1'b0;
            r_final  <= 1'b0;
            r_word   <= '0;
        end else begin
            r_state  <= n_state;
            r_pad    <= n_pad;
            r_first  <= n_first;
            r_len_ok <= n_len_ok;
            r_final  <= n_final;
            r_word   <= n_word;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);
    assign o_out_word  = r_word;
    assign o_out_last  = (r_word == WORD_LAST);

endmodule

>>> hdl/sha256_stream_hasher.sv
// top level of the sha-256 stream hasher: byte stream in, digest words out
// depends on sha_pkg, sha_ctrl and sha_dp
//
//  channel  | direction | tdata           | tuser          | tlast
//  s_axis   | in        | [7:0] data byte | byte present   | end of message
//  m_axis   | out       | [63:0] digest   | [1:0] word idx | fourth digest word
//
// a byte is written into the block when taken; the byte that completes a block adds 64 rounds and a fold
// a last item pads one byte per cycle to the end of the block and compresses it,
// pad and compress repeat for one more block when the length does not fit
// then each of the four digest words is held until taken
// the input is not ready while a block compresses, pads or the digest waits
// synchronous active-low reset returns the initial hash values, no clearing pass
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] byte_present
    input  logic        i_s_axis_tlast,   // last
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [63:0] digest_word
    output logic [1:0]  o_m_axis_tuser,   // [1:0] word_index
    output logic        o_m_axis_tlast    // final_word
);
    import sha_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // sequencing
    sha_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .o_in_ready   (o_s_axis_tready),
        .i_in_present (i_s_axis_tuser),
        .i_in_last    (i_s_axis_tlast),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_out_word   (o_m_axis_tuser),
        .o_out_last   (o_m_axis_tlast),
        .o_cmd        (cmd),
        .i_status     (status)
    );

    // hashing datapath
    sha_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_byte   (i_s_axis_tdata),
        .o_status (status),
        .o_digest (o_m_axis_tdata)
    );

endmodule

>>> hdl/sha_chk.sv
// port-level checker for the sha-256 stream hasher, bound to the top level
// depends on sha_pkg for the last word index
module sha_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [7:0]  i_s_axis_tdata,
    input logic        i_s_axis_tuser,
    input logic        i_s_axis_tlast,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [63:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);
    import sha_pkg::*;

    // a waiting input item holds until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && !o_s_axis_tready |=>
            i_s_axis_tvalid && $stable(i_s_axis_tdata) && $stable(i_s_axis_tuser)
            && $stable(i_s_axis_tlast))
        else $error("waiting input item changed");

    // a stalled digest item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled digest item changed");

    // tlast marks the fourth word only
    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tuser == WORD_LAST)))
        else $error("tlast does not match word index");

    // no input taken while a digest is shown
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("input ready during digest output");

    // words follow in order without gaps
    a_word_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=>
            o_m_axis_tvalid && (o_m_axis_tuser == $past(o_m_axis_tuser) + 2'd1))
        else $error("digest words out of order");

endmodule

bind sha256_stream_hasher sha_chk u_sha_chk (.*);
